// File: hw/rtl/closest_pair_search_defines.svh
// ----------------------------------------------------------------------------
// closest_pair_search_defines
// assertion macros shared by the closest pair search rtl
// ----------------------------------------------------------------------------
`ifndef CLOSEST_PAIR_SEARCH_DEFINES_SVH
`define CLOSEST_PAIR_SEARCH_DEFINES_SVH

// same-cycle implication, checked at every clock edge out of reset
`define CPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every clock edge out of reset
`define CPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/cps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg
// shared constants and command/status types of the closest pair search
// ----------------------------------------------------------------------------
package cps_pkg;

   // default sizing
   localparam int MAX_POINTS_DEF = 512;
   localparam int COORD_BITS_DEF = 17;

   // reset value of the limit register, 99999 squared
   localparam logic [63:0] LIMIT_RESET_SQ = 64'd9999800001;

   // commands from controller to datapath
   typedef struct packed {
      logic wr_en;        // store the incoming point
      logic search_init;  // load best with the limit, clear the pair
      logic issue;        // launch one pair into the distance pipeline
      logic emit;         // present the result this cycle
   } cps_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic best_zero;    // best distance is zero, nothing can beat it
      logic pipe_busy;    // pairs still in flight
   } cps_status_type;

endpackage

// File: hw/rtl/cps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_datapath
// point memory, pipelined squared distance unit and best pair tracking
// ----------------------------------------------------------------------------
module cps_datapath import cps_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_POINTS),
   localparam int DIST_W = 2 * COORD_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cps_cmd_type           cmd,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [IDX_W-1:0]      rd_i,
   input  logic [IDX_W-1:0]      rd_j,
   input  logic [COORD_BITS-1:0] point_x,
   input  logic [COORD_BITS-1:0] point_y,
   input  logic                  csr_we,
   input  logic [DIST_W-1:0]     csr_wdata,
   output cps_status_type        status,
   output logic [IDX_W-1:0]      first_index,
   output logic [IDX_W-1:0]      second_index,
   output logic [DIST_W-1:0]     min_dist_sq,
   output logic                  found
);

   localparam logic [DIST_W-1:0] LimitReset = DIST_W'(LIMIT_RESET_SQ);
   localparam int PT_W = 2 * COORD_BITS;
   localparam int SQ_W = 2 * COORD_BITS;

   logic [PT_W-1:0]       mem [MAX_POINTS];
   logic [DIST_W-1:0]     limit_ff;

   // stage 1: point pair read
   logic [PT_W-1:0]       pi_ff, pj_ff;
   logic                  v1_ff;
   logic [IDX_W-1:0]      i1_ff, j1_ff;
   // stage 2: coordinate differences
   logic [COORD_BITS-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic                  v2_ff;
   logic [IDX_W-1:0]      i2_ff, j2_ff;
   // stage 3: squares
   logic [SQ_W-1:0]       sqx_ff, sqy_ff;
   logic                  v3_ff;
   logic [IDX_W-1:0]      i3_ff, j3_ff;
   // stage 4: compare against best
   logic [DIST_W-1:0]     dist_sum;
   logic                  take_pair;
   logic [DIST_W-1:0]     best_ff;
   logic [IDX_W-1:0]      bi_ff, bj_ff;
   logic                  found_ff;

   logic [COORD_BITS-1:0] xi, yi, xj, yj;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // point memory, one write port and two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= {point_x, point_y};
      end
      pi_ff <= mem[rd_i];
      pj_ff <= mem[rd_j];
   end

   // absolute coordinate differences
   assign xi = pi_ff[PT_W-1:COORD_BITS];
   assign yi = pi_ff[COORD_BITS-1:0];
   assign xj = pj_ff[PT_W-1:COORD_BITS];
   assign yj = pj_ff[COORD_BITS-1:0];
   assign dx_in = (xi >= xj) ? (xi - xj) : (xj - xi);
   assign dy_in = (yi >= yj) ? (yi - yj) : (yj - yi);

   // pipeline data
   always_ff @(posedge clock) begin
      i1_ff  <= rd_i;
      j1_ff  <= rd_j;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      i2_ff  <= i1_ff;
      j2_ff  <= j1_ff;
      sqx_ff <= SQ_W'(dx_ff * dx_ff);
      sqy_ff <= SQ_W'(dy_ff * dy_ff);
      i3_ff  <= i2_ff;
      j3_ff  <= j2_ff;
   end

   // pipeline valid tags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // strict less-than keeps the earliest pair on a tie
   assign dist_sum  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign take_pair = v3_ff && (dist_sum < best_ff);

   // best pair so far
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         best_ff  <= LimitReset;
         bi_ff    <= '0;
         bj_ff    <= '0;
      end else if (cmd.search_init) begin
         found_ff <= 1'b0;
         best_ff  <= limit_ff;
         bi_ff    <= '0;
         bj_ff    <= '0;
      end else if (take_pair) begin
         found_ff <= 1'b1;
         best_ff  <= dist_sum;
         bi_ff    <= i3_ff;
         bj_ff    <= j3_ff;
      end
   end

   // status and result
   assign status.best_zero = (best_ff == '0);
   assign status.pipe_busy = v1_ff | v2_ff | v3_ff;
   assign first_index      = bi_ff;
   assign second_index     = bj_ff;
   assign min_dist_sq      = best_ff;
   assign found            = found_ff;

endmodule

// File: hw/rtl/cps_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_controller
// point loading, pair scan sequencing and result timing
// ----------------------------------------------------------------------------
module cps_controller import cps_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   localparam int IDX_W = $clog2(MAX_POINTS),
   localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             last_point,
   input  cps_status_type   status,
   output logic             busy,
   output cps_cmd_type      cmd,
   output logic [IDX_W-1:0] wr_addr,
   output logic [IDX_W-1:0] rd_i,
   output logic [IDX_W-1:0] rd_j
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic             accept;
   logic             has_room;
   logic [CNT_W-1:0] count_next;
   logic [CNT_W-1:0] j_plus1, i_plus2;

   assign accept     = start && (state_ff == S_IDLE);
   assign has_room   = (count_ff < CNT_W'(MAX_POINTS));
   assign count_next = has_room ? (count_ff + CNT_W'(1)) : count_ff;
   assign j_plus1    = CNT_W'(j_ff) + CNT_W'(1);
   assign i_plus2    = CNT_W'(i_ff) + CNT_W'(2);

   // next state and commands
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      i_in             = i_ff;
      j_in             = j_ff;
      cmd.wr_en        = 1'b0;
      cmd.search_init  = 1'b0;
      cmd.issue        = 1'b0;
      cmd.emit         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.wr_en = has_room;
               count_in  = count_next;
               if (last_point) begin
                  cmd.search_init = 1'b1;
                  i_in            = '0;
                  j_in            = IDX_W'(1);
                  state_in        = (count_next >= CNT_W'(2)) ? S_SCAN : S_DRAIN;
               end
            end
         end
         S_SCAN: begin
            // a zero distance cannot be beaten, stop launching pairs
            if (status.best_zero) begin
               state_in = S_DRAIN;
            end else begin
               cmd.issue = 1'b1;
               if (j_plus1 == count_ff) begin
                  if (i_plus2 >= count_ff) begin
                     state_in = S_DRAIN;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                     j_in = i_plus2[IDX_W-1:0];
                  end
               end else begin
                  j_in = j_plus1[IDX_W-1:0];
               end
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.emit = 1'b1;
            count_in = '0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   assign busy    = (state_ff != S_IDLE);
   assign wr_addr = count_ff[IDX_W-1:0];
   assign rd_i    = i_ff;
   assign rd_j    = j_ff;

endmodule

// File: hw/rtl/closest_pair_search.sv
`timescale 1ns / 1ps
`include "closest_pair_search_defines.svh"
// ----------------------------------------------------------------------------
// closest_pair_search
// Brute-force closest pair of 2-D points. While busy is low, one point is
// taken per cycle on start and stored in order; a point beyond MAX_POINTS
// is dropped. A request with req_last_point set starts a scan of every pair
// (i, j), i < j, in row order, comparing squared distances against the limit
// written on csr_wdata. A dual-read point memory feeds a four-stage distance
// pipeline, so the scan launches one pair per cycle; with fewer than two
// points no pair is launched. busy drops in the cycle after the result
// strobe. A zero distance ends the scan early. busy stays high for the whole
// search, and the result is shown for exactly one cycle with rsp_strobe; the
// receiver cannot stall it. rsp_found is low when no pair beat the limit, and
// then both indices are zero and rsp_min_dist_sq is the limit.
// ----------------------------------------------------------------------------
module closest_pair_search import cps_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_POINTS),
   localparam int DIST_W = 2 * COORD_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   input  logic                  req_last_point,
   output logic                  rsp_strobe,
   output logic [IDX_W-1:0]      rsp_first_index,
   output logic [IDX_W-1:0]      rsp_second_index,
   output logic [DIST_W-1:0]     rsp_min_dist_sq,
   output logic                  rsp_found,
   input  logic                  csr_we,
   input  logic [DIST_W-1:0]     csr_wdata
);

   cps_cmd_type      cmd;
   cps_status_type   status;
   logic [IDX_W-1:0] wr_addr, rd_i, rd_j;

   // sequencing
   cps_controller #(
      .MAX_POINTS(MAX_POINTS)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_point (req_last_point),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_i       (rd_i),
      .rd_j       (rd_j)
   );

   // storage and distance arithmetic
   cps_datapath #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .rd_i         (rd_i),
      .rd_j         (rd_j),
      .point_x      (req_point_x),
      .point_y      (req_point_y),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .status       (status),
      .first_index  (rsp_first_index),
      .second_index (rsp_second_index),
      .min_dist_sq  (rsp_min_dist_sq),
      .found        (rsp_found)
   );

   assign rsp_strobe = cmd.emit;

   // checks
   `CPS_ASSERT_NEXT(a_last_starts_search, start && !busy && req_last_point, busy, "search did not start")
   `CPS_ASSERT_NEXT(a_result_frees_block, rsp_strobe, !busy && !rsp_strobe, "block not idle after result")
   `CPS_ASSERT_NOW(a_pair_ordered, rsp_strobe && rsp_found, rsp_first_index < rsp_second_index, "pair indices out of order")
   `CPS_ASSERT_NOW(a_no_pair_zero_index, rsp_strobe && !rsp_found, rsp_first_index == '0 && rsp_second_index == '0, "indices set without a pair")
   `CPS_ASSERT_NOW(a_scan_has_no_issue_when_idle, !busy, !cmd.issue && !rsp_strobe, "pipeline activity while idle")

endmodule

// File: tb/sv/closest_pair_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_search_tb
// Self-checking bench for the closest pair search. Point sets are loaded one
// request at a time. The last point of a set starts the search, and the
// bench works out the expected pair on its own copy of the stored points and
// of the limit register. A short table of directed sets, some with
// hand-written results, runs first. Random sets of varied size and spread
// follow, two of them filling the store and one overflowing it. Limit
// writes happen only between sets, with the block drained.
// ----------------------------------------------------------------------------
module closest_pair_search_tb;
   import cps_pkg::*;

   localparam int COORD_W        = COORD_BITS_DEF;
   localparam int MAX_PTS        = MAX_POINTS_DEF;
   localparam int IDX_W          = $clog2(MAX_PTS);
   localparam int DIST_W         = 2 * COORD_W + 1;
   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 11;
   localparam int ITEM_TARGET    = 1800;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TIMEOUT_CYCLES = 2_000_000;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [DIST_W-1:0]  dist_type;

   localparam coord_type COORD_MAX   = '1;
   localparam dist_type  LIMIT_MAX   = 35'd34359214082;
   localparam dist_type  LIMIT_RESET = DIST_W'(LIMIT_RESET_SQ);

   typedef struct packed {
      idx_type  first_index;
      idx_type  second_index;
      dist_type min_dist_sq;
      logic     found;
   } pair_result_type;

   typedef enum int {ROW_POINT, ROW_LIMIT} row_kind_type;
   typedef enum int {SPREAD_FULL, SPREAD_TINY, SPREAD_HIGH, SPREAD_CLUSTER} spread_type;

   typedef struct {
      row_kind_type    kind;
      coord_type       x;
      coord_type       y;
      logic            last;
      bit              typed;
      pair_result_type want;
      dist_type        limit;
   } stim_row_type;

   // dut signals, the driven inputs known from time zero
   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   logic      req_last_point = 1'b0;
   logic      rsp_strobe;
   idx_type   rsp_first_index;
   idx_type   rsp_second_index;
   dist_type  rsp_min_dist_sq;
   logic      rsp_found;
   logic      csr_we = 1'b0;
   dist_type  csr_wdata = '0;

   // shadow of the block state
   coord_type shadow_x [MAX_PTS];
   coord_type shadow_y [MAX_PTS];
   int        shadow_count;
   dist_type  shadow_limit;

   pair_result_type pending_results[$];
   stim_row_type    directed_rows[$];
   int              mismatch_count;
   int              points_sent;

   closest_pair_search i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_last_point   (req_last_point),
      .rsp_strobe       (rsp_strobe),
      .rsp_first_index  (rsp_first_index),
      .rsp_second_index (rsp_second_index),
      .rsp_min_dist_sq  (rsp_min_dist_sq),
      .rsp_found        (rsp_found),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   // clock
   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // append one expected result to the scoreboard
   function automatic void expect_result(input pair_result_type r);
      pending_results = {pending_results, r};
   endfunction

   // brute-force scan over the shadow store, row order, strict less-than
   function automatic pair_result_type predict_closest_pair();
      pair_result_type  res;
      longint unsigned  best;
      longint unsigned  dx;
      longint unsigned  dy;
      longint unsigned  dd;
      bit               stop;
      res  = '0;
      best = shadow_limit;
      stop = 1'b0;
      for (int i = 0; i + 1 < shadow_count && !stop; i++) begin
         for (int j = i + 1; j < shadow_count && !stop; j++) begin
            dx = (shadow_x[i] >= shadow_x[j]) ? shadow_x[i] - shadow_x[j]
                                              : shadow_x[j] - shadow_x[i];
            dy = (shadow_y[i] >= shadow_y[j]) ? shadow_y[i] - shadow_y[j]
                                              : shadow_y[j] - shadow_y[i];
            dd = dx * dx + dy * dy;
            if (dd < best) begin
               best             = dd;
               res.first_index  = IDX_W'(i);
               res.second_index = IDX_W'(j);
               res.found        = 1'b1;
               stop             = (dd == 0);
            end
         end
      end
      res.min_dist_sq = DIST_W'(best);
      return res;
   endfunction

   function automatic pair_result_type pair_of(input int fi, input int si,
                                               input dist_type d, input logic f);
      pair_result_type r;
      r.first_index  = IDX_W'(fi);
      r.second_index = IDX_W'(si);
      r.min_dist_sq  = d;
      r.found        = f;
      return r;
   endfunction

   function automatic void add_row(input row_kind_type kind, input coord_type x,
                                   input coord_type y, input logic last, input bit typed,
                                   input pair_result_type want, input dist_type limit);
      stim_row_type row;
      row.kind  = kind;
      row.x     = x;
      row.y     = y;
      row.last  = last;
      row.typed = typed;
      row.want  = want;
      row.limit = limit;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic dist_type rand_limit();
      dist_type v;
      int       pick;
      pick = $urandom_range(9, 0);
      case (pick)
         0: v = '0;
         1: v = LIMIT_MAX;
         2: v = LIMIT_RESET;
         3: v = DIST_W'($urandom_range(200, 0));
         4: v = DIST_W'($urandom_range(1 << 20, 0));
         default: begin
            do v = {3'($urandom_range(7, 0)), 32'($urandom())};
            while (v > LIMIT_MAX);
         end
      endcase
      return v;
   endfunction

   function automatic int rand_gap(input bit burst);
      int r;
      r = $urandom_range(99, 0);
      if (burst || r < 60) return 0;
      else if (r < 95) return $urandom_range(3, 1);
      else return $urandom_range(60, 10);
   endfunction

   function automatic coord_type rand_coord(input spread_type spread, input coord_type base);
      case (spread)
         SPREAD_TINY:    return COORD_W'($urandom_range(7, 0));
         SPREAD_HIGH:    return COORD_MAX - COORD_W'($urandom_range(7, 0));
         SPREAD_CLUSTER: return base + COORD_W'($urandom_range(600, 0));
         default:        return COORD_W'($urandom());
      endcase
   endfunction

   // start low with noise on the request fields
   task automatic idle_cycles(input int n);
      for (int k = 0; k < n; k++) begin
         start          <= 1'b0;
         req_point_x    <= COORD_W'($urandom());
         req_point_y    <= COORD_W'($urandom());
         req_last_point <= 1'b0;
         @(negedge clock);
      end
   endtask

   // drive one request from a falling edge, hold until taken
   task automatic send_point(input coord_type x, input coord_type y, input logic last,
                             input bit typed, input pair_result_type want);
      pair_result_type calc;
      start          <= 1'b1;
      req_point_x    <= x;
      req_point_y    <= y;
      req_last_point <= last;
      do @(posedge clock); while (busy);
      if (shadow_count < MAX_PTS) begin
         shadow_x[shadow_count] = x;
         shadow_y[shadow_count] = y;
         shadow_count++;
      end
      if (last) begin
         calc = predict_closest_pair();
         expect_result(typed ? want : calc);
         shadow_count = 0;
      end
      points_sent++;
      @(negedge clock);
   endtask

   // limit write with the block drained and settled
   task automatic write_limit(input dist_type value);
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= DIST_W'($urandom());
      shadow_limit = value;
      @(negedge clock);
   endtask

   task automatic run_random_set(input int n, input spread_type spread);
      coord_type base;
      bit        burst;
      base  = COORD_W'($urandom_range(int'(COORD_MAX) - 600, 0));
      burst = ($urandom_range(3, 0) == 0);
      for (int k = 0; k < n; k++) begin
         idle_cycles(rand_gap(burst));
         send_point(rand_coord(spread, base), rand_coord(spread, base), k == n - 1,
                    1'b0, '0);
      end
   endtask

   // result checker, sampled at the rising edge
   always @(posedge clock) begin
      pair_result_type got;
      pair_result_type want;
      if (!reset && rsp_strobe) begin
         got = pair_of(rsp_first_index, rsp_second_index, rsp_min_dist_sq, rsp_found);
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result i=%0d j=%0d d=%0d found=%0d",
               got.first_index, got.second_index, got.min_dist_sq, got.found));
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf(
                  "got i=%0d j=%0d d=%0d found=%0d, want i=%0d j=%0d d=%0d found=%0d",
                  got.first_index, got.second_index, got.min_dist_sq, got.found,
                  want.first_index, want.second_index, want.min_dist_sq, want.found));
            end
         end
      end
   end

   // main sequence
   initial begin
      stim_row_type row;
      int           set_num;
      int           n;
      int           r;
      spread_type   spread;

      mismatch_count = 0;
      points_sent    = 0;
      shadow_count   = 0;
      shadow_limit   = LIMIT_RESET;

      // a lone point has no pair
      add_row(ROW_POINT, 0, 0, 1, 1, pair_of(0, 0, LIMIT_RESET, 0), '0);
      // opposite corners do not beat the reset limit
      add_row(ROW_POINT, 0, 0, 0, 0, '0, '0);
      add_row(ROW_POINT, COORD_MAX, COORD_MAX, 1, 1, pair_of(0, 0, LIMIT_RESET, 0), '0);
      // identical points
      add_row(ROW_POINT, COORD_MAX, 0, 0, 0, '0, '0);
      add_row(ROW_POINT, COORD_MAX, 0, 1, 1, pair_of(0, 1, 0, 1), '0);
      // zero distance ends the scan
      add_row(ROW_POINT, 1, 1, 0, 0, '0, '0);
      add_row(ROW_POINT, 2, 2, 0, 0, '0, '0);
      add_row(ROW_POINT, 1, 1, 0, 0, '0, '0);
      add_row(ROW_POINT, 2, 2, 1, 1, pair_of(0, 2, 0, 1), '0);
      // a tie keeps the earlier pair
      add_row(ROW_POINT, 0, 0, 0, 0, '0, '0);
      add_row(ROW_POINT, 3, 4, 0, 0, '0, '0);
      add_row(ROW_POINT, 6, 8, 1, 1, pair_of(0, 1, 25, 1), '0);
      // mixed set, predicted
      add_row(ROW_POINT, COORD_MAX, COORD_MAX, 0, 0, '0, '0);
      add_row(ROW_POINT, 0, 1, 0, 0, '0, '0);
      add_row(ROW_POINT, 65536, 65535, 0, 0, '0, '0);
      add_row(ROW_POINT, 65535, 65536, 1, 0, '0, '0);
      // zero limit rejects even a zero distance
      add_row(ROW_LIMIT, 0, 0, 0, 0, '0, '0);
      add_row(ROW_POINT, 7, 7, 0, 0, '0, '0);
      add_row(ROW_POINT, 7, 7, 1, 1, pair_of(0, 0, 0, 0), '0);
      // largest limit against the largest distances
      add_row(ROW_LIMIT, 0, 0, 0, 0, '0, LIMIT_MAX);
      add_row(ROW_POINT, 0, 0, 0, 0, '0, '0);
      add_row(ROW_POINT, COORD_MAX, COORD_MAX, 1, 1, pair_of(0, 0, LIMIT_MAX, 0), '0);
      add_row(ROW_POINT, 0, 0, 0, 0, '0, '0);
      add_row(ROW_POINT, COORD_MAX, COORD_MAX - 1, 1, 1,
              pair_of(0, 1, 35'd34358951941, 1), '0);
      add_row(ROW_LIMIT, 0, 0, 0, 0, '0, LIMIT_RESET);

      // reset
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.kind == ROW_LIMIT) begin
            write_limit(row.limit);
         end else begin
            idle_cycles($urandom_range(2, 0));
            send_point(row.x, row.y, row.last, row.typed, row.want);
         end
      end

      // random sets, two of them fill the store, one overflows it
      set_num = 0;
      while (points_sent < ITEM_TARGET) begin
         if ($urandom_range(9, 0) < 3) write_limit(rand_limit());
         r      = $urandom_range(99, 0);
         spread = spread_type'($urandom_range(3, 0));
         if (set_num == 15) begin
            n      = MAX_PTS;
            spread = SPREAD_FULL;
         end else if (set_num == 40) begin
            n      = MAX_PTS + 3;
            spread = SPREAD_CLUSTER;
         end else if (r < 10) begin
            n = 1;
         end else if (r < 80) begin
            n = $urandom_range(12, 2);
         end else begin
            n = $urandom_range(40, 13);
         end
         run_random_set(n, spread);
         set_num++;
      end

      // drain
      idle_cycles(1);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
